FILE: rtl/qcfp_pkg.sv
// ----------------------------------------------------------------------------
// qcfp_pkg
// Shared types and codes for the queuing channel FIFO pair.
// ----------------------------------------------------------------------------
package qcfp_pkg;

  localparam int CAP_W   = 5;
  localparam int CAP_MAX = 31;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RECV = 2'd1;
  localparam logic [1:0] CMD_XFER = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_EMPTY   = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] message;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] out_data;
    logic [4:0]         moved_count;
    logic [4:0]         source_level;
    logic [4:0]         dest_level;
  } rsp_t;

  typedef struct packed {
    logic       load;
    logic       norm;
    logic       push_src;
    logic       rd_dst;
    logic       pop_dst;
    logic       rd_src;
    logic       move;
    logic       set_status;
    logic [1:0] status;
    logic       load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       norm_done;
    logic       src_full;
    logic       src_empty;
    logic       src_head_valid;
    logic       dst_full;
    logic       dst_empty;
    logic       dst_head_valid;
  } dp_sts_t;

endpackage

FILE: rtl/qcfp_datapath.sv
// ----------------------------------------------------------------------------
// qcfp_datapath
// Queue storage, heads, levels, capacity register and result register.
// ----------------------------------------------------------------------------
module qcfp_datapath #(
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [qcfp_pkg::CAP_W-1:0] cfg_data,
  input  qcfp_pkg::req_t           req_item,
  input  qcfp_pkg::dp_cmd_t        cmd,
  output qcfp_pkg::dp_sts_t        sts,
  output qcfp_pkg::rsp_t           rsp_item
);

  // indices never reach the capacity register's maximum
  localparam int SLOTS = (DEPTH < qcfp_pkg::CAP_MAX) ? DEPTH : qcfp_pkg::CAP_MAX;
  localparam int IW    = $clog2(SLOTS);

  logic [4:0]         capacity;
  logic [4:0]         cap_eff;

  logic [1:0]         cmd_r;
  logic [31:0]        msg_r;
  logic [IW-1:0]      hs;
  logic [IW-1:0]      hd;
  logic [1:0]         status_r;
  logic [31:0]        data_r;
  logic [4:0]         moved_r;

  logic [IW-1:0]      src_head;
  logic [IW-1:0]      dst_head;
  logic [4:0]         src_count;
  logic [4:0]         dst_count;
  logic               src_valid [SLOTS];
  logic               dst_valid [SLOTS];

  logic [31:0]        src_mem [SLOTS];
  logic [31:0]        dst_mem [SLOTS];
  logic [31:0]        src_rd;
  logic [31:0]        dst_rd;

  logic [5:0]         src_sum;
  logic [5:0]         dst_sum;
  logic [IW-1:0]      src_tail;
  logic [IW-1:0]      dst_tail;
  logic [5:0]         hs_plus;
  logic [5:0]         hd_plus;
  logic [IW-1:0]      hs_inc;
  logic [IW-1:0]      hd_inc;
  logic               hs_ge;
  logic               hd_ge;
  logic [4:0]         hs_sub;
  logic [4:0]         hd_sub;

  always_comb begin
    if (capacity == 5'd0) begin
      cap_eff = 5'd1;
    end else if (32'(capacity) > SLOTS) begin
      cap_eff = 5'(SLOTS);
    end else begin
      cap_eff = capacity;
    end
  end

  // head < cap and count < cap wherever a tail is used: one wrap at most
  always_comb begin
    src_sum  = 6'(hs) + 6'(src_count);
    dst_sum  = 6'(hd) + 6'(dst_count);
    src_tail = (src_sum >= 6'(cap_eff)) ? IW'(src_sum - 6'(cap_eff)) : IW'(src_sum);
    dst_tail = (dst_sum >= 6'(cap_eff)) ? IW'(dst_sum - 6'(cap_eff)) : IW'(dst_sum);
    hs_plus  = 6'(hs) + 6'd1;
    hd_plus  = 6'(hd) + 6'd1;
    hs_inc   = (hs_plus >= 6'(cap_eff)) ? '0 : IW'(hs_plus);
    hd_inc   = (hd_plus >= 6'(cap_eff)) ? '0 : IW'(hd_plus);
    hs_ge    = 5'(hs) >= cap_eff;
    hd_ge    = 5'(hd) >= cap_eff;
    hs_sub   = 5'(hs) - cap_eff;
    hd_sub   = 5'(hd) - cap_eff;
  end

  always_comb begin
    sts.cmd            = cmd_r;
    sts.norm_done      = !hs_ge && !hd_ge;
    sts.src_full       = src_count >= cap_eff;
    sts.src_empty      = src_count == 5'd0;
    sts.src_head_valid = src_valid[hs];
    sts.dst_full       = dst_count >= cap_eff;
    sts.dst_empty      = dst_count == 5'd0;
    sts.dst_head_valid = dst_valid[hd];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= qcfp_pkg::CAP_RESET;
      src_head  <= '0;
      dst_head  <= '0;
      src_count <= '0;
      dst_count <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        src_valid[i] <= 1'b0;
        dst_valid[i] <= 1'b0;
      end
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      if (cmd.push_src) begin
        src_valid[src_tail] <= 1'b1;
        src_count           <= src_count + 5'd1;
      end
      if (cmd.pop_dst) begin
        dst_valid[hd] <= 1'b0;
        dst_head      <= hd_inc;
        dst_count     <= dst_count - 5'd1;
      end
      if (cmd.move) begin
        dst_valid[dst_tail] <= 1'b1;
        dst_count           <= dst_count + 5'd1;
        src_valid[hs]       <= 1'b0;
        src_head            <= hs_inc;
        src_count           <= src_count - 5'd1;
      end
    end
  end

  // working copies: stored heads stay raw, reduced modulo capacity per item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r    <= req_item.cmd;
      msg_r    <= req_item.message;
      hs       <= src_head;
      hd       <= dst_head;
      status_r <= qcfp_pkg::ST_OK;
      data_r   <= '0;
      moved_r  <= '0;
    end
    if (cmd.norm) begin
      if (hs_ge) begin
        hs <= IW'(hs_sub);
      end
      if (hd_ge) begin
        hd <= IW'(hd_sub);
      end
    end
    if (cmd.set_status) begin
      status_r <= cmd.status;
    end
    if (cmd.pop_dst) begin
      data_r <= dst_rd;
      hd     <= hd_inc;
    end
    if (cmd.move) begin
      hs      <= hs_inc;
      moved_r <= moved_r + 5'd1;
    end
    if (cmd.load_out) begin
      rsp_item.status       <= status_r;
      rsp_item.out_data     <= data_r;
      rsp_item.moved_count  <= moved_r;
      rsp_item.source_level <= src_count;
      rsp_item.dest_level   <= dst_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_src) begin
      src_mem[src_tail] <= msg_r;
    end
    if (cmd.rd_src) begin
      src_rd <= src_mem[hs];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.move) begin
      dst_mem[dst_tail] <= src_rd;
    end
    if (cmd.rd_dst) begin
      dst_rd <= dst_mem[hd];
    end
  end

endmodule

FILE: rtl/qcfp_ctrl.sv
// ----------------------------------------------------------------------------
// qcfp_ctrl
// Sequencer for send, receive and transfer; owns the result handshake.
// ----------------------------------------------------------------------------
module qcfp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  input  qcfp_pkg::dp_sts_t  sts,
  output qcfp_pkg::dp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    IDLE,
    NORM,
    XF_TEST,
    XF_MOVE,
    RX_POP,
    FIN
  } state_t;

  state_t state;
  state_t state_next;

  assign req_stall = state != IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = NORM;
        end
      end
      NORM: begin
        if (!sts.norm_done) begin
          cmd.norm = 1'b1;
        end else begin
          state_next = FIN;
          unique case (sts.cmd)
            qcfp_pkg::CMD_SEND: begin
              if (sts.src_full) begin
                cmd.set_status = 1'b1;
                cmd.status     = qcfp_pkg::ST_FULL;
              end else begin
                cmd.push_src = 1'b1;
              end
            end
            qcfp_pkg::CMD_RECV: begin
              if (sts.dst_empty) begin
                cmd.set_status = 1'b1;
                cmd.status     = qcfp_pkg::ST_EMPTY;
              end else if (!sts.dst_head_valid) begin
                cmd.set_status = 1'b1;
                cmd.status     = qcfp_pkg::ST_INVALID;
              end else begin
                cmd.rd_dst = 1'b1;
                state_next = RX_POP;
              end
            end
            qcfp_pkg::CMD_XFER: begin
              state_next = XF_TEST;
            end
            default: begin
              state_next = FIN;
            end
          endcase
        end
      end
      XF_TEST: begin
        if (sts.src_empty || sts.dst_full || !sts.src_head_valid) begin
          state_next = FIN;
        end else begin
          cmd.rd_src = 1'b1;
          state_next = XF_MOVE;
        end
      end
      XF_MOVE: begin
        cmd.move   = 1'b1;
        state_next = XF_TEST;
      end
      RX_POP: begin
        cmd.pop_dst = 1'b1;
        state_next  = FIN;
      end
      FIN: begin
        if (!rsp_valid || !rsp_stall) begin
          cmd.load_out = 1'b1;
          state_next   = IDLE;
        end
      end
      default: begin
        state_next = IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/queuing_channel_fifo_pair_unit.sv
// ----------------------------------------------------------------------------
// queuing_channel_fifo_pair_unit
// Inter-partition queuing channel: source and destination message queues.
// ----------------------------------------------------------------------------
//  channel  handshake               payload
//  req      req_valid / req_stall   req_item  (cmd, message)
//  rsp      rsp_valid / rsp_stall   rsp_item  (status, out_data, moved_count,
//                                              source_level, dest_level)
//  cfg      cfg_valid / cfg_ready   cfg_data  (capacity)
//
//  Send, unused command and failed receive end after the normalise step;
//  receive reads, then pops; transfer alternates test and move per entry
//  (one memory read then one write per entry). A head at or above the
//  capacity is reduced by one subtraction a cycle, on every item until that
//  head next moves. Reset clears valid marks and levels; no clearing pass.
//  A stalled result holds in the output register; the next item is taken
//  meanwhile and waits in its final step until the register frees.
// ----------------------------------------------------------------------------
module queuing_channel_fifo_pair_unit #(
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  qcfp_pkg::req_t             req_item,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output qcfp_pkg::rsp_t             rsp_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [qcfp_pkg::CAP_W-1:0] cfg_data
);

  localparam int SLOTS = (DEPTH < qcfp_pkg::CAP_MAX) ? DEPTH : qcfp_pkg::CAP_MAX;

  qcfp_pkg::dp_cmd_t cmd;
  qcfp_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  qcfp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  qcfp_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .req_item (req_item),
    .cmd      (cmd),
    .sts      (sts),
    .rsp_item (rsp_item)
  );

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> req_stall
  ) else $error("accepted item did not make the unit busy");

  a_result_after_work: assert property (
    @(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall)
  ) else $error("result raised without an item in progress");

  a_levels_bounded: assert property (
    @(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(rsp_item.source_level) <= SLOTS) &&
                  (32'(rsp_item.dest_level) <= SLOTS)
  ) else $error("queue level beyond slot count");

endmodule

FILE: verif/queuing_channel_fifo_pair_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// queuing_channel_fifo_pair_unit_tb
// Self-checking bench for the queuing channel: a directed table covers the
// field extremes, every command, full/empty/invalid-head reports and odd
// capacity values, then random send/transfer/receive bursts run under
// several capacities and handshake idling patterns. Typed steps are checked against
// their table reply, the others against a behavioural model of both circular queues.
// ----------------------------------------------------------------------------
module queuing_channel_fifo_pair_unit_tb;

  localparam int DEPTH      = 16;
  localparam int SRC        = 0;
  localparam int DST        = 1;
  localparam int LIMIT      = 2000;
  localparam int HOLD_LEN   = 300;
  localparam int TAIL_WAIT  = 50;
  localparam int PHASE_LEN  = 115;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam qcfp_pkg::rsp_t NO_REPLY = '0;

  typedef struct packed {
    logic [4:0]     cap;
    logic [1:0]     cmd;
    logic [31:0]    msg;
    logic           typed;
    qcfp_pkg::rsp_t want;
  } step_t;

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       req_valid;
  logic                       req_stall;
  qcfp_pkg::req_t             req_item;
  logic                       rsp_valid;
  logic                       rsp_stall = 1'b0;
  qcfp_pkg::rsp_t             rsp_item;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [qcfp_pkg::CAP_W-1:0] cfg_data;

  // queue model: index 0 is the sending side, 1 the receiving side
  logic [31:0]      slot_word [2][DEPTH];
  bit               slot_mark [2][DEPTH];
  int unsigned      q_first [2];
  int unsigned      q_fill [2];
  logic [4:0]       cap_mirror;

  qcfp_pkg::rsp_t   reply_q [$];
  bit               pin_typed;
  qcfp_pkg::rsp_t   pin_reply;
  int               errors;
  int               idle_cycles;
  bit               took;
  qcfp_pkg::rsp_t   model_out;
  qcfp_pkg::rsp_t   want;

  int               send_idle = 10;
  int               recv_idle = 51;
  bit               hold_req;
  int               hold_left;
  logic [4:0]       cur_cap;

  queuing_channel_fifo_pair_unit #(.DEPTH(DEPTH)) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned live_cap();
    int unsigned c;
    c = 32'(cap_mirror);
    if (c < 1) c = 1;
    if (c > DEPTH) c = DEPTH;
    return c;
  endfunction

  function automatic void enqueue(int q, int unsigned cap, logic [31:0] w);
    int unsigned tail;
    tail = ((q_first[q] % cap) + q_fill[q]) % cap;
    slot_word[q][tail] = w;
    slot_mark[q][tail] = 1'b1;
    q_fill[q]++;
  endfunction

  function automatic void drop_head(int q, int unsigned cap);
    int unsigned h;
    h = q_first[q] % cap;
    slot_word[q][h] = '0;
    slot_mark[q][h] = 1'b0;
    q_first[q] = (h + 1) % cap;
    q_fill[q]--;
  endfunction

  function automatic qcfp_pkg::rsp_t channel_step(qcfp_pkg::req_t r);
    int unsigned cap;
    int unsigned h;
    int unsigned moved;
    qcfp_pkg::rsp_t res;
    cap = live_cap();
    moved = 0;
    res = '0;
    res.status = qcfp_pkg::ST_OK;
    case (r.cmd)
      qcfp_pkg::CMD_SEND: begin
        if (q_fill[SRC] >= cap) res.status = qcfp_pkg::ST_FULL;
        else enqueue(SRC, cap, r.message);
      end
      qcfp_pkg::CMD_RECV: begin
        if (q_fill[DST] == 0) begin
          res.status = qcfp_pkg::ST_EMPTY;
        end else begin
          h = q_first[DST] % cap;
          if (!slot_mark[DST][h]) begin
            res.status = qcfp_pkg::ST_INVALID;
          end else begin
            res.out_data = slot_word[DST][h];
            drop_head(DST, cap);
          end
        end
      end
      qcfp_pkg::CMD_XFER: begin
        while (q_fill[SRC] > 0 && q_fill[DST] < cap) begin
          h = q_first[SRC] % cap;
          if (!slot_mark[SRC][h]) break;
          enqueue(DST, cap, slot_word[SRC][h]);
          drop_head(SRC, cap);
          moved++;
        end
      end
      default: ;
    endcase
    res.moved_count  = moved[4:0];
    res.source_level = q_fill[SRC][4:0];
    res.dest_level   = q_fill[DST][4:0];
    return res;
  endfunction

  task automatic report(input string field, input logic [31:0] exp_v,
                        input logic [31:0] act_v);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v, act_v);
  endtask

  // accept, predict, compare
  always @(posedge clk) begin
    if (!rst) begin
      took = 1'b0;
      if (cfg_valid && cfg_ready) begin
        cap_mirror = cfg_data;
        took = 1'b1;
      end
      if (req_valid && !req_stall) begin
        model_out = channel_step(req_item);
        reply_q.push_back(pin_typed ? pin_reply : model_out);
        took = 1'b1;
      end
      if (rsp_valid && !rsp_stall) begin
        took = 1'b1;
        if (reply_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %0h", $time, rsp_item);
        end else begin
          want = reply_q.pop_front();
          if (rsp_item.status !== want.status)
            report("status", 32'(want.status), 32'(rsp_item.status));
          if (rsp_item.out_data !== want.out_data)
            report("out_data", want.out_data, rsp_item.out_data);
          if (rsp_item.moved_count !== want.moved_count)
            report("moved_count", 32'(want.moved_count), 32'(rsp_item.moved_count));
          if (rsp_item.source_level !== want.source_level)
            report("source_level", 32'(want.source_level), 32'(rsp_item.source_level));
          if (rsp_item.dest_level !== want.dest_level)
            report("dest_level", 32'(want.dest_level), 32'(rsp_item.dest_level));
        end
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
      if (idle_cycles >= LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_LEN;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic put_item(input logic [1:0] c, input logic [31:0] m);
    while ($urandom_range(99) < send_idle) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req_item  <= {c, m};
    do @(posedge clk); while (req_stall);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(negedge clk); while (reply_q.size() != 0);
  endtask

  task automatic write_capacity(input logic [4:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    cur_cap = v;
  endtask

  task automatic drain_queues();
    int tries;
    wait_idle();
    for (tries = 0; tries < 64 && (q_fill[SRC] != 0 || q_fill[DST] != 0); tries++) begin
      if (q_fill[DST] != 0) repeat (q_fill[DST]) put_item(qcfp_pkg::CMD_RECV, $urandom);
      else put_item(qcfp_pkg::CMD_XFER, $urandom);
      wait_idle();
    end
  endtask

  function automatic logic [31:0] rand_word();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    step_t steps [25];
    int i;
    int ph;
    int sent;
    int k;
    bit paused;
    bit held;

    rst       = 1'b1;
    req_valid = 1'b0;
    req_item  = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    errors    = 0;
    pin_typed = 1'b0;
    pin_reply = '0;
    cap_mirror = qcfp_pkg::CAP_RESET;
    cur_cap   = qcfp_pkg::CAP_RESET;
    for (i = 0; i < DEPTH; i++) begin
      slot_word[SRC][i] = '0; slot_mark[SRC][i] = 1'b0;
      slot_word[DST][i] = '0; slot_mark[DST][i] = 1'b0;
    end
    q_first[SRC] = 0; q_fill[SRC] = 0;
    q_first[DST] = 0; q_fill[DST] = 0;

    // empty queues after reset, extremes of the message word
    steps[0]  = {5'd16, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_EMPTY, 32'h0, 5'd0, 5'd0, 5'd0};
    steps[1]  = {5'd16, qcfp_pkg::CMD_XFER, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd0, 5'd0, 5'd0};
    steps[2]  = {5'd16, CMD_NONE, 32'hffff_ffff, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd0, 5'd0, 5'd0};
    steps[3]  = {5'd16, qcfp_pkg::CMD_SEND, 32'h7fff_ffff, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd0, 5'd1, 5'd0};
    steps[4]  = {5'd16, qcfp_pkg::CMD_SEND, 32'h8000_0000, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd0, 5'd2, 5'd0};
    steps[5]  = {5'd16, qcfp_pkg::CMD_XFER, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd2, 5'd0, 5'd2};
    steps[6]  = {5'd16, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h7fff_ffff, 5'd0, 5'd0, 5'd1};
    steps[7]  = {5'd16, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h8000_0000, 5'd0, 5'd0, 5'd0};
    // zero capacity behaves as one slot
    steps[8]  = {5'd0, qcfp_pkg::CMD_SEND, 32'h0, 1'b0, NO_REPLY};
    steps[9]  = {5'd0, qcfp_pkg::CMD_SEND, 32'hffff_ffff, 1'b0, NO_REPLY};
    steps[10] = {5'd0, qcfp_pkg::CMD_XFER, 32'h0, 1'b0, NO_REPLY};
    steps[11] = {5'd0, qcfp_pkg::CMD_RECV, 32'h0, 1'b0, NO_REPLY};
    // three slots: full source, full destination, wrap
    steps[12] = {5'd3, qcfp_pkg::CMD_SEND, 32'h5555_5555, 1'b0, NO_REPLY};
    steps[13] = {5'd3, qcfp_pkg::CMD_SEND, 32'haaaa_aaaa, 1'b0, NO_REPLY};
    steps[14] = {5'd3, qcfp_pkg::CMD_SEND, 32'h0000_0001, 1'b0, NO_REPLY};
    steps[15] = {5'd3, qcfp_pkg::CMD_SEND, 32'h0000_0002, 1'b0, NO_REPLY};
    steps[16] = {5'd3, qcfp_pkg::CMD_XFER, 32'h0, 1'b0, NO_REPLY};
    steps[17] = {5'd3, qcfp_pkg::CMD_SEND, 32'hffff_fffe, 1'b0, NO_REPLY};
    steps[18] = {5'd3, qcfp_pkg::CMD_XFER, 32'h0, 1'b0, NO_REPLY};
    steps[19] = {5'd3, qcfp_pkg::CMD_RECV, 32'h0, 1'b0, NO_REPLY};
    steps[20] = {5'd3, qcfp_pkg::CMD_RECV, 32'h0, 1'b0, NO_REPLY};
    // shrinking to two slots lands the head on a cleared slot
    steps[21] = {5'd2, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_INVALID, 32'h0, 5'd0, 5'd1, 5'd1};
    steps[22] = {5'd3, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h1, 5'd0, 5'd1, 5'd0};
    // above depth acts as full depth
    steps[23] = {5'd31, qcfp_pkg::CMD_XFER, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'h0, 5'd1, 5'd0, 5'd1};
    steps[24] = {5'd31, qcfp_pkg::CMD_RECV, 32'h0, 1'b1,
                 qcfp_pkg::ST_OK, 32'hffff_fffe, 5'd0, 5'd0, 5'd0};

    repeat (2) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (i = 0; i < 25; i++) begin
      if (steps[i].cap != cur_cap) begin
        wait_idle();
        write_capacity(steps[i].cap);
      end
      pin_typed = steps[i].typed;
      pin_reply = steps[i].want;
      put_item(steps[i].cmd, steps[i].msg);
    end
    pin_typed = 1'b0;

    paused = 1'b0;
    held   = 1'b0;
    for (ph = 0; ph < 6; ph++) begin
      send_idle = (ph < 2) ? 10 : (ph < 4) ? 51 : 0;
      recv_idle = (ph < 2) ? 51 : (ph < 4) ? 10 : 0;
      // capacity changes only on empty queues so heads stay on live slots
      drain_queues();
      case (ph)
        0:       write_capacity(5'd16);
        1:       write_capacity(5'd5);
        2:       write_capacity(5'd1);
        3:       write_capacity(5'd31);
        4:       write_capacity(5'd0);
        default: write_capacity(5'($urandom_range(15, 2)));
      endcase
      sent = 0;
      while (sent < PHASE_LEN) begin
        if (ph == 1 && sent >= 50 && !paused) begin
          wait_idle();
          paused = 1'b1;
        end
        if (ph == 4 && sent >= 40 && !held) begin
          hold_req = 1'b1;
          held = 1'b1;
        end
        if ($urandom_range(99) < 70) begin
          k = $urandom_range(1, live_cap() + 1);
          repeat (k) put_item(qcfp_pkg::CMD_SEND, rand_word());
          put_item(qcfp_pkg::CMD_XFER, $urandom);
          repeat (k) put_item(qcfp_pkg::CMD_RECV, $urandom);
          sent += 2 * k + 1;
        end else begin
          put_item(2'($urandom_range(3)), rand_word());
          sent++;
        end
      end
    end

    wait_idle();
    repeat (TAIL_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
